### rtl/core/cpcr_pkg.sv
// ----------------------------------------------------------------------------
// cpcr_pkg
// Types, constants and helpers shared by the circle pair collision response.
// ----------------------------------------------------------------------------
package cpcr_pkg;

  localparam int SQRT_STEPS = 32;
  localparam int SPD_STEPS  = 32;
  localparam int NRM_STEPS  = 17;
  localparam int CFG_AW     = 3;

  localparam logic [31:0] TIME_STEP_RESET = 32'd1092;

  typedef enum logic {
    REG_TIME_STEP = 1'b0,
    REG_PAUSED    = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic signed [31:0] a_pos_x;
    logic signed [31:0] a_pos_y;
    logic [30:0]        a_radius;
    logic               a_movable;
    logic signed [31:0] b_pos_x;
    logic signed [31:0] b_pos_y;
    logic [30:0]        b_radius;
    logic               b_movable;
  } cpcr_in_t;

  typedef struct packed {
    logic               hit;
    logic signed [31:0] a_dvel_x;
    logic signed [31:0] a_dvel_y;
    logic signed [31:0] b_dvel_x;
    logic signed [31:0] b_dvel_y;
  } cpcr_out_t;

  typedef struct packed {
    logic [31:0] time_step;
    logic        paused;
  } cpcr_cfg_t;

  typedef struct packed {
    logic        dx_neg;
    logic        dy_neg;
    logic [31:0] ux;
    logic [31:0] uy;
    logic [31:0] sr;
    logic        am;
    logic        bm;
    logic        hit;
    logic        go;
  } cpcr_side_t;

  function automatic logic [31:0] sat_pos(input logic [31:0] p);
    return p[31] ? 32'h7FFF_FFFF : p;
  endfunction

  function automatic logic [31:0] sat_neg(input logic [31:0] p);
    return p[31] ? 32'h8000_0000 : (32'd0 - p);
  endfunction

endpackage

### rtl/core/cpcr_if.sv
// ----------------------------------------------------------------------------
// cpcr_if
// Valid/ready channels for circle pairs and for collision results.
// ----------------------------------------------------------------------------
interface cpcr_in_if;
  import cpcr_pkg::*;
  logic     valid;
  logic     ready;
  cpcr_in_t data;
  modport source(output valid, data, input ready);
  modport sink(input valid, data, output ready);
endinterface

interface cpcr_out_if;
  import cpcr_pkg::*;
  logic      valid;
  logic      ready;
  cpcr_out_t data;
  modport source(output valid, data, input ready);
  modport sink(input valid, data, output ready);
endinterface

### rtl/core/circle_pair_collision_response.sv
// throughput: one pair per cycle; the whole pipeline holds while the result stalls
// the depth comes from the 32-stage square root and the 32-stage speed divider
// synchronous active-low reset clears all valid bits and sets time_step to 1092,
// paused to 0
// ----------------------------------------------------------------------------
// circle_pair_collision_response
// Overlap test and velocity response for one pair of circles per transaction.
// ----------------------------------------------------------------------------
module circle_pair_collision_response (
  input  logic                         clk,
  input  logic                         rst_n,
  cpcr_in_if.sink                      in_ch,
  cpcr_out_if.source                   out_ch,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [cpcr_pkg::CFG_AW-1:0]  paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);
  import cpcr_pkg::*;

  logic       en;
  cpcr_cfg_t  cfg;

  logic        f_v;
  logic [63:0] f_s;
  cpcr_side_t  f_side;
  logic        q_v;
  logic [31:0] q_root;
  cpcr_side_t  q_side;
  logic        d_v;
  logic [31:0] d_speed;
  logic [16:0] d_nx, d_ny;
  cpcr_side_t  d_side;
  logic        o_v;
  cpcr_out_t   o_data;

  assign en           = !o_v || out_ch.ready;
  assign in_ch.ready  = en;
  assign out_ch.valid = o_v;
  assign out_ch.data  = o_data;

  cpcr_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  cpcr_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_ch.valid),
    .in_data   (in_ch.data),
    .paused    (cfg.paused),
    .out_valid (f_v),
    .out_s     (f_s),
    .out_side  (f_side)
  );

  cpcr_sqrt u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (f_v),
    .in_s      (f_s),
    .in_side   (f_side),
    .out_valid (q_v),
    .out_root  (q_root),
    .out_side  (q_side)
  );

  cpcr_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (q_v),
    .in_dist   (q_root),
    .in_side   (q_side),
    .time_step (cfg.time_step),
    .out_valid (d_v),
    .out_speed (d_speed),
    .out_nx    (d_nx),
    .out_ny    (d_ny),
    .out_side  (d_side)
  );

  cpcr_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (d_v),
    .in_speed  (d_speed),
    .in_nx     (d_nx),
    .in_ny     (d_ny),
    .in_side   (d_side),
    .out_valid (o_v),
    .out_data  (o_data)
  );

`ifndef SYNTHESIS
  a_nohit_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (o_v && !o_data.hit) |-> (o_data.a_dvel_x == 32'sd0 && o_data.a_dvel_y == 32'sd0 &&
      o_data.b_dvel_x == 32'sd0 && o_data.b_dvel_y == 32'sd0))
    else $error("velocity change without hit");

  a_opposite_x: assert property (@(posedge clk) disable iff (!rst_n)
    (o_v && o_data.a_dvel_x != 32'sd0 && o_data.b_dvel_x != 32'sd0) |->
      (o_data.a_dvel_x[31] != o_data.b_dvel_x[31]))
    else $error("a and b x changes share a sign");

  a_paused_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (f_v && cfg.paused && $stable(cfg.paused)) |-> !f_side.hit)
    else $error("hit raised while paused");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !o_v)
    else $error("result valid after reset");
`endif

endmodule

### rtl/core/cpcr_regs.sv
// ----------------------------------------------------------------------------
// cpcr_regs
// APB-style register file holding the time step and the pause flag.
// ----------------------------------------------------------------------------
module cpcr_regs (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [cpcr_pkg::CFG_AW-1:0]  paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  output cpcr_pkg::cpcr_cfg_t          cfg
);
  import cpcr_pkg::*;

  logic [31:0] time_step_r, time_step_nxt;
  logic        paused_r, paused_nxt;
  logic        wr;
  cfg_reg_t    idx;

  assign wr     = psel & penable & pwrite;
  assign idx    = cfg_reg_t'(paddr[2]);
  assign pready = 1'b1;

  always_comb begin
    time_step_nxt = time_step_r;
    paused_nxt    = paused_r;
    if (wr) begin
      unique case (idx)
        REG_TIME_STEP: time_step_nxt = pwdata;
        REG_PAUSED:    paused_nxt    = pwdata[0];
        default:       ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_TIME_STEP: prdata = time_step_r;
      REG_PAUSED:    prdata = {31'd0, paused_r};
      default:       prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      time_step_r <= TIME_STEP_RESET;
      paused_r    <= 1'b0;
    end else begin
      time_step_r <= time_step_nxt;
      paused_r    <= paused_nxt;
    end
  end

  assign cfg.time_step = time_step_r;
  assign cfg.paused    = paused_r;

endmodule

### rtl/core/cpcr_front.sv
// ----------------------------------------------------------------------------
// cpcr_front
// Center differences, squared distance and the overlap test, three stages.
// ----------------------------------------------------------------------------
module cpcr_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_valid,
  input  cpcr_pkg::cpcr_in_t   in_data,
  input  logic                 paused,
  output logic                 out_valid,
  output logic [63:0]          out_s,
  output cpcr_pkg::cpcr_side_t out_side
);
  import cpcr_pkg::*;

  logic signed [32:0] dx_w, dy_w;
  logic [32:0]        ndx_w, ndy_w;

  logic        v1_r, v2_r, v3_r;
  logic [31:0] ux1_r, uy1_r, sr1_r;
  logic        xn1_r, yn1_r, am1_r, bm1_r, pz1_r;
  logic [63:0] sx2_r, sy2_r, sr2_r;
  logic [31:0] ux2_r, uy2_r, sr2b_r;
  logic        xn2_r, yn2_r, am2_r, bm2_r, pz2_r;
  logic [64:0] sum_w;
  logic        hit_w;
  logic [63:0] s3_r;
  cpcr_side_t  side3_r;

  assign dx_w  = {in_data.b_pos_x[31], in_data.b_pos_x} - {in_data.a_pos_x[31], in_data.a_pos_x};
  assign dy_w  = {in_data.b_pos_y[31], in_data.b_pos_y} - {in_data.a_pos_y[31], in_data.a_pos_y};
  assign ndx_w = 33'd0 - dx_w;
  assign ndy_w = 33'd0 - dy_w;

  assign sum_w = {1'b0, sx2_r} + {1'b0, sy2_r};
  assign hit_w = !pz2_r && !sum_w[64] && (sum_w[63:0] < sr2_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ux1_r <= dx_w[32] ? ndx_w[31:0] : dx_w[31:0];
      uy1_r <= dy_w[32] ? ndy_w[31:0] : dy_w[31:0];
      xn1_r <= dx_w[32];
      yn1_r <= dy_w[32];
      sr1_r <= {1'b0, in_data.a_radius} + {1'b0, in_data.b_radius};
      am1_r <= in_data.a_movable;
      bm1_r <= in_data.b_movable;
      pz1_r <= paused;

      sx2_r  <= 64'(ux1_r) * 64'(ux1_r);
      sy2_r  <= 64'(uy1_r) * 64'(uy1_r);
      sr2_r  <= 64'(sr1_r) * 64'(sr1_r);
      ux2_r  <= ux1_r;
      uy2_r  <= uy1_r;
      sr2b_r <= sr1_r;
      xn2_r  <= xn1_r;
      yn2_r  <= yn1_r;
      am2_r  <= am1_r;
      bm2_r  <= bm1_r;
      pz2_r  <= pz1_r;

      s3_r           <= sum_w[63:0];
      side3_r.dx_neg <= xn2_r;
      side3_r.dy_neg <= yn2_r;
      side3_r.ux     <= ux2_r;
      side3_r.uy     <= uy2_r;
      side3_r.sr     <= sr2b_r;
      side3_r.am     <= am2_r;
      side3_r.bm     <= bm2_r;
      side3_r.hit    <= hit_w;
      side3_r.go     <= hit_w && (sum_w[63:0] != 64'd0) && (am2_r || bm2_r);
    end
  end

  assign out_valid = v3_r;
  assign out_s     = s3_r;
  assign out_side  = side3_r;

endmodule

### rtl/core/cpcr_sqrt.sv
// ----------------------------------------------------------------------------
// cpcr_sqrt
// Pipelined integer square root, one root bit per stage.
// ----------------------------------------------------------------------------
module cpcr_sqrt (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic [63:0]          in_s,
  input  cpcr_pkg::cpcr_side_t in_side,
  output logic                 out_valid,
  output logic [31:0]          out_root,
  output cpcr_pkg::cpcr_side_t out_side
);
  import cpcr_pkg::*;

  localparam int N = SQRT_STEPS;

  logic        st_v    [0:N];
  logic [63:0] st_rem  [0:N];
  logic [31:0] st_root [0:N];
  cpcr_side_t  st_side [0:N];

  logic        v_r    [0:N-1];
  logic [63:0] rem_r  [0:N-1];
  logic [31:0] root_r [0:N-1];
  cpcr_side_t  side_r [0:N-1];

  assign st_v[0]    = in_valid;
  assign st_rem[0]  = in_s;
  assign st_root[0] = 32'd0;
  assign st_side[0] = in_side;

  for (genvar k = 0; k < N; k++) begin : g_stage
    localparam int B = N - 1 - k;
    logic [64:0] cand;
    logic        take;
    logic [63:0] rem_nxt;
    logic [31:0] root_nxt;

    always_comb begin
      cand     = (65'(st_root[k]) << (B + 1)) | (65'd1 << (2 * B));
      take     = {1'b0, st_rem[k]} >= cand;
      rem_nxt  = take ? (st_rem[k] - cand[63:0]) : st_rem[k];
      root_nxt = take ? (st_root[k] | (32'd1 << B)) : st_root[k];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= st_v[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= rem_nxt;
        root_r[k] <= root_nxt;
        side_r[k] <= st_side[k];
      end
    end

    assign st_v[k+1]    = v_r[k];
    assign st_rem[k+1]  = rem_r[k];
    assign st_root[k+1] = root_r[k];
    assign st_side[k+1] = side_r[k];
  end

  assign out_valid = st_v[N];
  assign out_root  = st_root[N];
  assign out_side  = st_side[N];

endmodule

### rtl/core/cpcr_div.sv
// ----------------------------------------------------------------------------
// cpcr_div
// Overlap, then pipelined restoring dividers for the separation speed and
// the two normal components.
// ----------------------------------------------------------------------------
module cpcr_div (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic [31:0]          in_dist,
  input  cpcr_pkg::cpcr_side_t in_side,
  input  logic [31:0]          time_step,
  output logic                 out_valid,
  output logic [31:0]          out_speed,
  output logic [16:0]          out_nx,
  output logic [16:0]          out_ny,
  output cpcr_pkg::cpcr_side_t out_side
);
  import cpcr_pkg::*;

  localparam int N = SPD_STEPS;

  logic [31:0] ovl_w;
  logic [32:0] dv_w;

  logic        v0_r;
  logic [31:0] dist0_r;
  logic [32:0] dv0_r;
  logic [31:0] ovl0_r;
  logic        sat0_r;
  cpcr_side_t  side0_r;

  logic        st_v    [0:N];
  logic [47:0] st_srem [0:N];
  logic [31:0] st_sq   [0:N];
  logic [47:0] st_xrem [0:N];
  logic [47:0] st_yrem [0:N];
  logic [16:0] st_xq   [0:N];
  logic [16:0] st_yq   [0:N];

  logic        v_r    [0:N-1];
  logic [47:0] srem_r [0:N-1];
  logic [31:0] sq_r   [0:N-1];
  logic [47:0] xrem_r [0:N-1];
  logic [47:0] yrem_r [0:N-1];
  logic [16:0] xq_r   [0:N-1];
  logic [16:0] yq_r   [0:N-1];
  logic        sat_r  [0:N-1];
  logic [31:0] dist_r [0:N-1];
  logic [32:0] dv_r   [0:N-1];
  cpcr_side_t  side_r [0:N-1];

  logic        st_sat  [0:N];
  logic [31:0] st_dist [0:N];
  logic [32:0] st_dv   [0:N];
  cpcr_side_t  st_side [0:N];

  assign ovl_w = in_side.sr - in_dist;
  assign dv_w  = (in_side.am && in_side.bm) ? {time_step, 1'b0} : {1'b0, time_step};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (en) begin
      v0_r <= in_valid;
    end
  end

  // saturate when the quotient would reach 2^32, zero divisor included
  always_ff @(posedge clk) begin
    if (en) begin
      dist0_r <= in_dist;
      dv0_r   <= dv_w;
      ovl0_r  <= ovl_w;
      sat0_r  <= {17'd0, ovl_w} >= {dv_w, 16'd0};
      side0_r <= in_side;
    end
  end

  assign st_v[0]    = v0_r;
  assign st_srem[0] = {ovl0_r, 16'd0};
  assign st_sq[0]   = 32'd0;
  assign st_xrem[0] = {side0_r.ux, 16'd0};
  assign st_yrem[0] = {side0_r.uy, 16'd0};
  assign st_xq[0]   = 17'd0;
  assign st_yq[0]   = 17'd0;
  assign st_sat[0]  = sat0_r;
  assign st_dist[0] = dist0_r;
  assign st_dv[0]   = dv0_r;
  assign st_side[0] = side0_r;

  for (genvar k = 0; k < N; k++) begin : g_stage
    localparam int B = N - 1 - k;
    logic [64:0] strial;
    logic        stake;
    logic [47:0] srem_nxt;
    logic [31:0] sq_nxt;
    logic [47:0] xrem_nxt, yrem_nxt;
    logic [16:0] xq_nxt, yq_nxt;

    always_comb begin
      strial   = 65'(st_dv[k]) << B;
      stake    = 65'(st_srem[k]) >= strial;
      srem_nxt = stake ? (st_srem[k] - strial[47:0]) : st_srem[k];
      sq_nxt   = stake ? (st_sq[k] | (32'd1 << B)) : st_sq[k];
    end

    if (k < NRM_STEPS) begin : g_nrm
      localparam int J = NRM_STEPS - 1 - k;
      logic [48:0] ntrial;
      logic        xtake, ytake;

      always_comb begin
        ntrial   = 49'(st_dist[k]) << J;
        xtake    = 49'(st_xrem[k]) >= ntrial;
        ytake    = 49'(st_yrem[k]) >= ntrial;
        xrem_nxt = xtake ? (st_xrem[k] - ntrial[47:0]) : st_xrem[k];
        yrem_nxt = ytake ? (st_yrem[k] - ntrial[47:0]) : st_yrem[k];
        xq_nxt   = xtake ? (st_xq[k] | (17'd1 << J)) : st_xq[k];
        yq_nxt   = ytake ? (st_yq[k] | (17'd1 << J)) : st_yq[k];
      end
    end else begin : g_pass
      always_comb begin
        xrem_nxt = st_xrem[k];
        yrem_nxt = st_yrem[k];
        xq_nxt   = st_xq[k];
        yq_nxt   = st_yq[k];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= st_v[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        srem_r[k] <= srem_nxt;
        sq_r[k]   <= sq_nxt;
        xrem_r[k] <= xrem_nxt;
        yrem_r[k] <= yrem_nxt;
        xq_r[k]   <= xq_nxt;
        yq_r[k]   <= yq_nxt;
        sat_r[k]  <= st_sat[k];
        dist_r[k] <= st_dist[k];
        dv_r[k]   <= st_dv[k];
        side_r[k] <= st_side[k];
      end
    end

    assign st_v[k+1]    = v_r[k];
    assign st_srem[k+1] = srem_r[k];
    assign st_sq[k+1]   = sq_r[k];
    assign st_xrem[k+1] = xrem_r[k];
    assign st_yrem[k+1] = yrem_r[k];
    assign st_xq[k+1]   = xq_r[k];
    assign st_yq[k+1]   = yq_r[k];
    assign st_sat[k+1]  = sat_r[k];
    assign st_dist[k+1] = dist_r[k];
    assign st_dv[k+1]   = dv_r[k];
    assign st_side[k+1] = side_r[k];
  end

  assign out_valid = st_v[N];
  assign out_speed = st_sat[N] ? 32'hFFFF_FFFF : st_sq[N];
  assign out_nx    = st_xq[N];
  assign out_ny    = st_yq[N];
  assign out_side  = st_side[N];

endmodule

### rtl/core/cpcr_back.sv
// ----------------------------------------------------------------------------
// cpcr_back
// Scales the normal by the speed, applies signs and saturation, and holds
// the result register.
// ----------------------------------------------------------------------------
module cpcr_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic [31:0]          in_speed,
  input  logic [16:0]          in_nx,
  input  logic [16:0]          in_ny,
  input  cpcr_pkg::cpcr_side_t in_side,
  output logic                 out_valid,
  output cpcr_pkg::cpcr_out_t  out_data
);
  import cpcr_pkg::*;

  logic [48:0] prx_w, pry_w;
  logic        v1_r, v2_r;
  logic [31:0] px1_r, py1_r;
  cpcr_side_t  side1_r;
  cpcr_out_t   res_w, res_r;

  assign prx_w = 49'(in_nx) * 49'(in_speed);
  assign pry_w = 49'(in_ny) * 49'(in_speed);

  always_comb begin
    res_w.hit      = side1_r.hit;
    res_w.a_dvel_x = 32'sd0;
    res_w.a_dvel_y = 32'sd0;
    res_w.b_dvel_x = 32'sd0;
    res_w.b_dvel_y = 32'sd0;
    if (side1_r.go && side1_r.bm) begin
      res_w.b_dvel_x = side1_r.dx_neg ? sat_neg(px1_r) : sat_pos(px1_r);
      res_w.b_dvel_y = side1_r.dy_neg ? sat_neg(py1_r) : sat_pos(py1_r);
    end
    if (side1_r.go && side1_r.am) begin
      res_w.a_dvel_x = side1_r.dx_neg ? sat_pos(px1_r) : sat_neg(px1_r);
      res_w.a_dvel_y = side1_r.dy_neg ? sat_pos(py1_r) : sat_neg(py1_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      px1_r   <= prx_w[47:16];
      py1_r   <= pry_w[47:16];
      side1_r <= in_side;
      res_r   <= res_w;
    end
  end

  assign out_valid = v2_r;
  assign out_data  = res_r;

endmodule
